### rtl/core/fpt2d_pkg.sv
// Shared constants and helpers for the temperature-to-display-character formatter.
package fpt2d_pkg;

   // Integer part of the magnitude and its decimal form
   localparam int BIN_W   = 12;
   localparam int DIG_N   = 4;
   localparam int BCD_W   = 4 * DIG_N;
   localparam int CNT_W   = $clog2(BIN_W);
   localparam int IDX_W   = $clog2(DIG_N);

   // Character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_UNIT  = 8'h63;
   localparam logic [7:0] DOT_BIT    = 8'h80;

   // Tenths digit of a 4-bit fraction: frac * 10 / 16, truncated
   function automatic logic [3:0] tenths_of(input logic [3:0] frac);
      logic [7:0] prod;
      prod = {4'b0000, frac} * 8'd10;
      return prod[7:4];
   endfunction

endpackage

### rtl/core/fixed_point_temperature_to_display_chars_unit.sv
// Top level of the temperature-to-display-character formatter.
//
// Each accepted sample (signed 12.4 temperature and a start position) becomes a
// string of 3 to 7 characters: an optional '-', the integer digits without
// leading zeros (the last one carrying the dot bit 0x80), one tenths digit and
// 'c', which is flagged by last. Positions count up from start_offset and wrap
// at 256. One sample is handled at a time: after the accept edge the 12-bit
// integer magnitude runs through a bit-serial shift-add-3 converter, whose done
// flag lets the sequencer register the index of the leading digit, then the
// characters leave one per cycle while the result side does not stall; a new
// sample is accepted only once the last character is loaded. The result register
// lets the next sample be accepted while the final 'c' still waits to be taken.
module fixed_point_temperature_to_display_chars_unit
   import fpt2d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_temperature,
   input  logic [7:0]         req_start_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_char_code,
   output logic [7:0]         rsp_position,
   output logic               rsp_last
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CONV = 3'd1;
   localparam logic [2:0] S_SIGN = 3'd2;
   localparam logic [2:0] S_DIG  = 3'd3;
   localparam logic [2:0] S_TEN  = 3'd4;
   localparam logic [2:0] S_UNIT = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic              neg_ff, neg_in;
   logic [3:0]        tenths_ff, tenths_in;
   logic [7:0]        pos_ff, pos_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic [7:0]        rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic [15:0]       mag;
   logic              bcd_done;
   logic [BCD_W-1:0]  bcd;
   logic [IDX_W-1:0]  first_idx;
   logic [BCD_W-1:0]  bcd_sel;
   logic              load;
   logic              have;
   logic [7:0]        next_char;
   logic              next_last;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Magnitude; the most negative value wraps to 0x8000, integer part 2048
   always_comb begin
      if (req_temperature[15]) begin
         mag = 16'(~req_temperature) + 16'd1;
      end else begin
         mag = req_temperature;
      end
   end

   fpt2d_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .bin   (mag[15:4]),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   // Most significant nonzero digit, at least the ones digit
   always_comb begin
      first_idx = '0;
      for (int d = 1; d < DIG_N; d++) begin
         if (bcd[4*d +: 4] != 4'd0) begin
            first_idx = IDX_W'(d);
         end
      end
   end

   assign bcd_sel = bcd >> {idx_ff, 2'b00};

   // Pick the character for the current phase
   always_comb begin
      have      = 1'b1;
      next_char = CHAR_UNIT;
      next_last = 1'b0;
      unique case (state_ff)
         S_SIGN: next_char = CHAR_MINUS;
         S_DIG: begin
            next_char = CHAR_ZERO | {4'b0000, bcd_sel[3:0]};
            if (idx_ff == '0) begin
               next_char = next_char | DOT_BIT;
            end
         end
         S_TEN:  next_char = CHAR_ZERO | {4'b0000, tenths_ff};
         S_UNIT: next_last = 1'b1;
         default: have = 1'b0;
      endcase
   end

   assign load = have && (!rsp_valid_ff || !rsp_stall);

   // Sequence the sample: convert, then hand out characters
   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      tenths_in = tenths_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_CONV;
               neg_in    = req_temperature[15];
               tenths_in = tenths_of(mag[3:0]);
               pos_in    = req_start_offset;
            end
         end
         S_CONV: begin
            if (bcd_done) begin
               state_in = neg_ff ? S_SIGN : S_DIG;
               idx_in   = first_idx;
            end
         end
         S_SIGN: begin
            if (load) state_in = S_DIG;
         end
         S_DIG: begin
            if (load) begin
               if (idx_ff == '0) begin
                  state_in = S_TEN;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         S_TEN: begin
            if (load) state_in = S_UNIT;
         end
         S_UNIT: begin
            if (load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (load) begin
         pos_in = pos_ff + 8'd1;
      end
   end

   // Hold the result register until its transfer, refill on load
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = next_char;
         rsp_pos_in   = pos_ff;
         rsp_last_in  = next_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      tenths_ff   <= tenths_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### rtl/core/fpt2d_bcd.sv
// Bit-serial shift-add-3 binary to BCD converter, one input bit per cycle.
module fpt2d_bcd
   import fpt2d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [BIN_W-1:0]   bin,
   output logic               done,
   output logic [BCD_W-1:0]   bcd
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   adj;

   // Add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < DIG_N; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   // Load on start, then shift one bit in per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = bin;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[BIN_W-1]};
         bin_in = {bin_ff[BIN_W-2:0], 1'b0};
         if (cnt_ff == CNT_W'(BIN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule
